[rtl/ncp_pkg.sv]
`timescale 1ns / 1ps

package ncp_pkg;

    localparam int KIND_W     = 2;
    localparam int CIDX_W     = 4;
    localparam int DIDX_W     = 2;
    localparam int COORD_W    = 16;
    localparam int RES_W      = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int ACT_W      = 5;
    localparam int DIMS_W     = 3;

    localparam int MAX_CENTROIDS = 16;
    localparam int MAX_DIMS      = 4;
    localparam int MAX_POINTS    = 65536;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POINT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd3;

    localparam logic REPLY_ASSIGN = 1'b0;
    localparam logic REPLY_REPORT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 1'b1;

    localparam logic [ACT_W-1:0]  ACTIVE_RESET = 5'd16;
    localparam logic [DIMS_W-1:0] DIMS_RESET   = 3'd3;

    typedef struct packed {
        logic                      wr_en;
        logic [CIDX_W-1:0]         wr_cidx;
        logic [DIDX_W-1:0]         wr_didx;
        logic signed [COORD_W-1:0] wr_data;
        logic                      clr_cnt;
        logic                      acc_clr;
        logic                      acc_en;
        logic                      inc_en;
        logic [ACT_W-1:0]          eff_nc;
    } t_cell_ctl;

endpackage

[rtl/ncp_req_if.sv]
`timescale 1ns / 1ps

interface ncp_req_if;
    logic                               valid;
    logic                               ready;
    logic [ncp_pkg::KIND_W-1:0]         kind;
    logic [ncp_pkg::CIDX_W-1:0]         centroid_index;
    logic [ncp_pkg::DIDX_W-1:0]         dim_index;
    logic signed [ncp_pkg::COORD_W-1:0] coord_value;

    modport source (
        output valid, kind, centroid_index, dim_index, coord_value,
        input  ready
    );
    modport sink (
        input  valid, kind, centroid_index, dim_index, coord_value,
        output ready
    );
endinterface

[rtl/ncp_rsp_if.sv]
`timescale 1ns / 1ps

interface ncp_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       reply_kind;
    logic [ncp_pkg::CIDX_W-1:0] bucket;
    logic [ncp_pkg::RES_W-1:0]  rank_in_bucket;
    logic [ncp_pkg::RES_W-1:0]  bucket_count;
    logic [ncp_pkg::RES_W-1:0]  bucket_offset;

    modport source (
        output valid, reply_kind, bucket, rank_in_bucket, bucket_count, bucket_offset,
        input  ready
    );
    modport sink (
        input  valid, reply_kind, bucket, rank_in_bucket, bucket_count, bucket_offset,
        output ready
    );
endinterface

[rtl/ncp_cell.sv]
`timescale 1ns / 1ps

module ncp_cell #(
    parameter int IDX = 0,
    localparam int CW  = (ncp_pkg::MAX_CENTROIDS > 1) ? $clog2(ncp_pkg::MAX_CENTROIDS) : 1,
    localparam int DSW = (ncp_pkg::MAX_DIMS > 1) ? $clog2(ncp_pkg::MAX_DIMS) : 1,
    localparam int DW  = 33 + $clog2(ncp_pkg::MAX_DIMS),
    localparam int NW  = $clog2(ncp_pkg::MAX_POINTS + 1),
    localparam int TW  = 7 + DW + CW + 2 * NW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ncp_pkg::t_cell_ctl  i_ctl,
    input  logic [DSW-1:0]      i_dim_sel,
    input  logic signed [15:0]  i_pt_coord,
    input  logic [CW-1:0]       i_win_idx,
    input  logic [TW-1:0]       i_tok,
    output logic [TW-1:0]       o_tok
);

    localparam int NW1 = NW + 1;
    localparam logic [NW-1:0]  SAT   = NW'(ncp_pkg::MAX_POINTS);
    localparam logic [NW1-1:0] SAT_X = NW1'(ncp_pkg::MAX_POINTS);

    typedef struct packed {
        logic          vld;
        logic          rpt;
        logic          have;
        logic [3:0]    tgt;
        logic [DW-1:0] dsq;
        logic [CW-1:0] idx;
        logic [NW-1:0] cnt;
        logic [NW-1:0] off;
    } t_token;

    t_token              tin;
    t_token              tout;
    t_token              r_tok;
    logic signed [15:0]  r_coord [ncp_pkg::MAX_DIMS];
    logic signed [16:0]  r_diff;
    logic [32:0]         r_sq;
    logic [DW-1:0]       r_acc;
    logic [NW-1:0]       r_cnt;
    logic signed [33:0]  prod;
    logic [NW1-1:0]      off_sum;
    logic                hit_wr;
    logic                active;

    assign tin    = t_token'(i_tok);
    assign o_tok  = r_tok;
    assign hit_wr = i_ctl.wr_en && (int'(i_ctl.wr_cidx) == IDX);
    assign active = IDX < int'(i_ctl.eff_nc);
    assign prod   = r_diff * r_diff;

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < ncp_pkg::MAX_DIMS; d++) begin
            if (hit_wr && int'(i_ctl.wr_didx) == d) begin
                r_coord[d] <= i_ctl.wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff <= {i_pt_coord[15], i_pt_coord}
                - {r_coord[i_dim_sel][15], r_coord[i_dim_sel]};
        r_sq   <= prod[32:0];
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + DW'(r_sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.clr_cnt) begin
            r_cnt <= '0;
        end else if (i_ctl.inc_en && i_win_idx == CW'(IDX) && r_cnt < SAT) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        tout    = tin;
        off_sum = {1'b0, tin.off} + {1'b0, r_cnt};
        if (tin.rpt) begin
            if (IDX < int'(tin.tgt)) begin
                tout.off = (off_sum > SAT_X) ? SAT : off_sum[NW-1:0];
            end
            if (IDX == int'(tin.tgt)) begin
                tout.cnt = r_cnt;
            end
        end else if (active && (!tin.have || r_acc < tin.dsq)) begin
            tout.have = 1'b1;
            tout.dsq  = r_acc;
            tout.idx  = CW'(IDX);
            tout.cnt  = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= tout;
        end
    end

endmodule

[rtl/nearest_centroid_partition.sv]
`timescale 1ns / 1ps
// nearest-centroid assignment with per-bucket point counts
// i_req carries one request: kind 0 loads one centroid coordinate, kind 1 one
// point coordinate, kind 2 clears all counts, kind 3 asks for a bucket report.
// o_rsp carries one result for the last coordinate of a point (bucket and rank)
// and for each report (count and exclusive prefix offset); kinds 0 and 2 and
// earlier point coordinates give none. i_cfg_* writes active_centroids
// (index 0) and dims_in_use (index 1). the user must write them only while
// the block is idle; the block itself does not enforce this. kinds 0 and 2
// and non-final point coordinates leave the block idle for the next request.
// after a point's last coordinate, each centroid cell runs a
// difference-square-accumulate pass over the coordinates, then a token walks
// the row of MAX_CENTROIDS cells, one cell per cycle, keeping the nearest one.
// a report's token walks the same row and sums the lower counts.
// one point or report is worked at a time; i_req.ready is high while idle,
// also while a finished result still waits in the output register.
// reset restores the registers to 16 centroids and 3 dims and clears counts;
// centroid and point coordinates are undefined until written.
// when o_rsp stalls, the result holds and the next result waits in the block.

module nearest_centroid_partition (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ncp_req_if.sink                           i_req,
    ncp_rsp_if.source                         o_rsp,
    input  logic                              i_cfg_we,
    input  logic [ncp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ncp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int NCENT = ncp_pkg::MAX_CENTROIDS;
    localparam int NDIMS = ncp_pkg::MAX_DIMS;
    localparam int CW  = (NCENT > 1) ? $clog2(NCENT) : 1;
    localparam int DSW = (NDIMS > 1) ? $clog2(NDIMS) : 1;
    localparam int DW  = 33 + $clog2(NDIMS);
    localparam int NW  = $clog2(ncp_pkg::MAX_POINTS + 1);
    localparam int TW  = 7 + DW + CW + 2 * NW;

    typedef struct packed {
        logic          vld;
        logic          rpt;
        logic          have;
        logic [3:0]    tgt;
        logic [DW-1:0] dsq;
        logic [CW-1:0] idx;
        logic [NW-1:0] cnt;
        logic [NW-1:0] off;
    } t_token;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIST  = 5'b00010,
        S_WAIT  = 5'b00100,
        S_CHAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [ncp_pkg::ACT_W-1:0]       r_active;
    logic [ncp_pkg::DIMS_W-1:0]      r_dims;
    logic signed [15:0]              r_pt [NDIMS];
    logic [DSW-1:0]                  r_dim;
    logic                            r_v1;
    logic                            r_v2;
    logic                            r_res_kind;
    logic [3:0]                      r_res_bucket;
    logic [ncp_pkg::RES_W-1:0]       r_res_rank;
    logic [ncp_pkg::RES_W-1:0]       r_res_cnt;
    logic [ncp_pkg::RES_W-1:0]       r_res_off;
    logic [CW-1:0]                   r_win;
    logic                            r_assign;
    logic                            r_out_vld;
    logic                            r_out_kind;
    logic [3:0]                      r_out_bucket;
    logic [ncp_pkg::RES_W-1:0]       r_out_rank;
    logic [ncp_pkg::RES_W-1:0]       r_out_cnt;
    logic [ncp_pkg::RES_W-1:0]       r_out_off;

    logic [ncp_pkg::ACT_W-1:0]       eff_nc;
    logic [ncp_pkg::DIMS_W-1:0]      eff_dims;
    logic                            accept;
    logic                            is_last;
    logic                            last_issue;
    logic                            launch_pt;
    logic                            launch_rpt;
    logic                            out_free;
    logic                            out_load;
    ncp_pkg::t_cell_ctl              ctl;
    t_token                          tok0;
    t_token                          tok_end;
    logic [TW-1:0]                   w_tok [NCENT+1];

    always_comb begin
        if (r_active == '0) begin
            eff_nc = ncp_pkg::ACT_W'(1);
        end else if (int'(r_active) > NCENT) begin
            eff_nc = ncp_pkg::ACT_W'(NCENT);
        end else begin
            eff_nc = r_active;
        end
        if (r_dims == '0) begin
            eff_dims = ncp_pkg::DIMS_W'(1);
        end else if (int'(r_dims) > NDIMS) begin
            eff_dims = ncp_pkg::DIMS_W'(NDIMS);
        end else begin
            eff_dims = r_dims;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign is_last     = int'(i_req.dim_index) == int'(eff_dims) - 1;
    assign last_issue  = int'(r_dim) == int'(eff_dims) - 1;
    assign launch_pt   = (r_state == S_WAIT) && !r_v1 && !r_v2;
    assign launch_rpt  = accept && i_req.kind == ncp_pkg::KIND_REPORT;
    assign out_free    = !r_out_vld || o_rsp.ready;
    assign out_load    = (r_state == S_DONE) && out_free;

    always_comb begin
        ctl.wr_en   = accept && i_req.kind == ncp_pkg::KIND_LOAD;
        ctl.wr_cidx = i_req.centroid_index;
        ctl.wr_didx = i_req.dim_index;
        ctl.wr_data = i_req.coord_value;
        ctl.clr_cnt = accept && i_req.kind == ncp_pkg::KIND_CLEAR;
        ctl.acc_clr = accept && i_req.kind == ncp_pkg::KIND_POINT && is_last;
        ctl.acc_en  = r_v2;
        ctl.inc_en  = out_load && r_assign;
        ctl.eff_nc  = eff_nc;
    end

    always_comb begin
        tok0     = '0;
        tok0.vld = launch_pt || launch_rpt;
        tok0.rpt = launch_rpt;
        tok0.tgt = i_req.centroid_index;
    end

    assign w_tok[0] = tok0;
    assign tok_end  = t_token'(w_tok[NCENT]);

    for (genvar g = 0; g < NCENT; g++) begin : g_cell
        ncp_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_dim_sel  (r_dim),
            .i_pt_coord (r_pt[r_dim]),
            .i_win_idx  (r_win),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ncp_pkg::ACTIVE_RESET;
            r_dims   <= ncp_pkg::DIMS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ncp_pkg::CFG_ACTIVE: r_active <= i_cfg_data[ncp_pkg::ACT_W-1:0];
                ncp_pkg::CFG_DIMS:   r_dims   <= i_cfg_data[ncp_pkg::DIMS_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < NDIMS; d++) begin
            if (accept && i_req.kind == ncp_pkg::KIND_POINT
                    && int'(i_req.dim_index) == d) begin
                r_pt[d] <= i_req.coord_value;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (launch_rpt) begin
                    n_state = S_CHAIN;
                end else if (ctl.acc_clr) begin
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                if (last_issue) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (launch_pt) begin
                    n_state = S_CHAIN;
                end
            end
            S_CHAIN: begin
                if (tok_end.vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_dim   <= '0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_DIST);
            r_v2    <= r_v1;
            if (ctl.acc_clr) begin
                r_dim <= '0;
            end else if (r_state == S_DIST && !last_issue) begin
                r_dim <= r_dim + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHAIN && tok_end.vld) begin
            r_assign <= !tok_end.rpt;
            r_win    <= tok_end.idx;
            if (tok_end.rpt) begin
                r_res_kind   <= ncp_pkg::REPLY_REPORT;
                r_res_bucket <= tok_end.tgt;
                r_res_rank   <= '0;
                r_res_cnt    <= ncp_pkg::RES_W'(tok_end.cnt);
                r_res_off    <= ncp_pkg::RES_W'(tok_end.off);
            end else begin
                r_res_kind   <= ncp_pkg::REPLY_ASSIGN;
                r_res_bucket <= 4'(tok_end.idx);
                r_res_rank   <= ncp_pkg::RES_W'(tok_end.cnt);
                r_res_cnt    <= '0;
                r_res_off    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind   <= r_res_kind;
            r_out_bucket <= r_res_bucket;
            r_out_rank   <= r_res_rank;
            r_out_cnt    <= r_res_cnt;
            r_out_off    <= r_res_off;
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.reply_kind     = r_out_kind;
    assign o_rsp.bucket         = r_out_bucket;
    assign o_rsp.rank_in_bucket = r_out_rank;
    assign o_rsp.bucket_count   = r_out_cnt;
    assign o_rsp.bucket_offset  = r_out_off;

endmodule

[rtl/ncp_checker.sv]
`timescale 1ns / 1ps

module ncp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic                         i_reply_kind,
    input logic [ncp_pkg::CIDX_W-1:0]   i_bucket,
    input logic [ncp_pkg::RES_W-1:0]    i_rank,
    input logic [ncp_pkg::RES_W-1:0]    i_count,
    input logic [ncp_pkg::RES_W-1:0]    i_offset
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_reply_kind)
            && $stable(i_bucket) && $stable(i_rank) && $stable(i_count)
            && $stable(i_offset))
        else $error("response changed while stalled");

    a_assign_fields: assert property (@(posedge i_clk)
        i_rsp_valid && i_reply_kind == ncp_pkg::REPLY_ASSIGN
            |-> i_count == '0 && i_offset == '0)
        else $error("assignment carries report fields");

    a_report_fields: assert property (@(posedge i_clk)
        i_rsp_valid && i_reply_kind == ncp_pkg::REPLY_REPORT |-> i_rank == '0)
        else $error("report carries a rank");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

endmodule

bind nearest_centroid_partition ncp_checker u_ncp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_reply_kind (o_rsp.reply_kind),
    .i_bucket     (o_rsp.bucket),
    .i_rank       (o_rsp.rank_in_bucket),
    .i_count      (o_rsp.bucket_count),
    .i_offset     (o_rsp.bucket_offset)
);

[dv/ncp_checker.sv]
`timescale 1ns / 1ps

module ncp_scoreboard #(
    parameter int NCENT      = 16,
    parameter int NDIMS      = 4,
    parameter int MAX_POINTS = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ncp_req_if                             i_req,
    ncp_rsp_if                             i_rsp,
    input  logic                           i_cfg_we,
    input  logic [ncp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ncp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);
    import ncp_pkg::*;

    typedef struct packed {
        logic              reply_kind;
        logic [CIDX_W-1:0] bucket;
        logic [RES_W-1:0]  rank;
        logic [RES_W-1:0]  count;
        logic [RES_W-1:0]  offset;
    } t_reply;

    logic signed [COORD_W-1:0] centroids [NCENT][NDIMS];
    logic signed [COORD_W-1:0] point_coords [NDIMS];
    logic [RES_W-1:0]          tallies [NCENT];
    logic [ACT_W-1:0]          active_reg;
    logic [DIMS_W-1:0]         dims_reg;
    t_reply                    replies_due [$];

    function automatic int clamp_count(input int raw, input int top);
        if (raw < 1) return 1;
        if (raw > top) return top;
        return raw;
    endfunction

    function automatic longint unsigned distance_sq(input int c, input int nd);
        longint unsigned acc;
        int              diff;
        acc = 0;
        for (int k = 0; k < nd; k++) begin
            diff = int'(point_coords[k]) - int'(centroids[c][k]);
            acc += longint'(diff) * longint'(diff);
        end
        return acc;
    endfunction

    // nearest centroid, lowest index on ties, then bump its count
    function automatic t_reply assign_point(input int nd);
        t_reply          r;
        int              nc;
        int              best;
        longint unsigned best_d;
        longint unsigned d;
        nc     = clamp_count(int'(active_reg), NCENT);
        best   = 0;
        best_d = distance_sq(0, nd);
        for (int c = 1; c < nc; c++) begin
            d = distance_sq(c, nd);
            if (d < best_d) begin
                best_d = d;
                best   = c;
            end
        end
        r            = '0;
        r.reply_kind = REPLY_ASSIGN;
        r.bucket     = best[CIDX_W-1:0];
        r.rank       = tallies[best];
        if (int'(tallies[best]) < MAX_POINTS) tallies[best] = tallies[best] + 1'b1;
        return r;
    endfunction

    function automatic t_reply bucket_report(input int b);
        t_reply r;
        int     off;
        off = 0;
        for (int c = 0; c < b; c++) begin
            off += int'(tallies[c]);
            if (off > MAX_POINTS) off = MAX_POINTS;
        end
        r            = '0;
        r.reply_kind = REPLY_REPORT;
        r.bucket     = b[CIDX_W-1:0];
        r.count      = tallies[b];
        r.offset     = off[RES_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        if (o_errors < 40) begin
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
        end
        o_errors++;
    endtask

    always @(posedge i_clk) begin : watch
        t_reply got;
        t_reply want;
        int     nd;
        if (!i_rst_n) begin
            foreach (tallies[c]) tallies[c] = '0;
            active_reg = ACTIVE_RESET;
            dims_reg   = DIMS_RESET;
            replies_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ACTIVE) begin
                    active_reg = i_cfg_data[ACT_W-1:0];
                end else if (i_cfg_idx == CFG_DIMS) begin
                    dims_reg = i_cfg_data[DIMS_W-1:0];
                end
            end
            if (i_req.valid && i_req.ready) begin
                case (i_req.kind)
                    KIND_LOAD: begin
                        centroids[i_req.centroid_index][i_req.dim_index] = i_req.coord_value;
                    end
                    KIND_POINT: begin
                        point_coords[i_req.dim_index] = i_req.coord_value;
                        nd = clamp_count(int'(dims_reg), NDIMS);
                        if (int'(i_req.dim_index) == nd - 1) begin
                            replies_due.push_back(assign_point(nd));
                        end
                    end
                    KIND_CLEAR: begin
                        foreach (tallies[c]) tallies[c] = '0;
                    end
                    KIND_REPORT: begin
                        replies_due.push_back(bucket_report(int'(i_req.centroid_index)));
                    end
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.reply_kind = i_rsp.reply_kind;
                got.bucket     = i_rsp.bucket;
                got.rank       = i_rsp.rank_in_bucket;
                got.count      = i_rsp.bucket_count;
                got.offset     = i_rsp.bucket_offset;
                if (replies_due.size() == 0) begin
                    note_mismatch("result with nothing pending, bucket", -1, got.bucket);
                end else begin
                    want = replies_due.pop_front();
                    if (got.reply_kind !== want.reply_kind) begin
                        note_mismatch("reply_kind", want.reply_kind, got.reply_kind);
                    end
                    if (got.bucket !== want.bucket) begin
                        note_mismatch("bucket", want.bucket, got.bucket);
                    end
                    if (got.rank !== want.rank) begin
                        note_mismatch("rank_in_bucket", want.rank, got.rank);
                    end
                    if (got.count !== want.count) begin
                        note_mismatch("bucket_count", want.count, got.count);
                    end
                    if (got.offset !== want.offset) begin
                        note_mismatch("bucket_offset", want.offset, got.offset);
                    end
                end
            end
        end
        o_pending = replies_due.size();
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ncp_pkg::*;

    localparam int NCENT       = 16;
    localparam int NDIMS       = 4;
    localparam int MAX_POINTS  = 65536;
    localparam int SETTLE      = NDIMS + NCENT + 12;
    localparam int CYCLE_LIMIT = 8000000;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    errors;
    int                    pending;
    int                    cycle_count = 0;

    logic signed [COORD_W-1:0] cen_shadow [NCENT][NDIMS];
    int                        use_nc     = NCENT;
    int                        use_dims   = 3;
    int                        burst_left = 0;
    int                        items_sent = 0;
    bit                        gap_on     = 1'b0;
    bit                        stall_free = 1'b0;
    int                        stall_pct  = 0;
    int                        stall_run  = 0;

    ncp_req_if req_if ();
    ncp_rsp_if rsp_if ();

    nearest_centroid_partition uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ncp_scoreboard #(
        .NCENT      (NCENT),
        .NDIMS      (NDIMS),
        .MAX_POINTS (MAX_POINTS)
    ) chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .i_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always #2 i_clk = ~i_clk;

    // result side stalls in runs of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (stall_free) begin
            rsp_if.ready <= 1'b1;
        end else if (stall_run == 0) begin
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            stall_run    <= $urandom_range(1, 8);
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_req(input logic [KIND_W-1:0] k, input int c, input int d,
                            input int v);
        if (burst_left == 0) begin
            if (gap_on) begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        req_if.valid          <= 1'b1;
        req_if.kind           <= k;
        req_if.centroid_index <= CIDX_W'(c);
        req_if.dim_index      <= DIDX_W'(d);
        req_if.coord_value    <= COORD_W'(v);
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic load_centroid(input int c, input int k, input int v);
        cen_shadow[c][k] = COORD_W'(v);
        push_req(KIND_LOAD, c, k, v);
    endtask

    // 0 near a centroid, 1 anywhere, 2 on a centroid, 3 at a corner
    function automatic int point_coord(input int style, input int c, input int k);
        int v;
        case (style)
            0: begin
                v = int'(cen_shadow[c][k]) + int'($urandom_range(0, 128)) - 64;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                return v;
            end
            1: return int'($urandom);
            2: return int'(cen_shadow[c][k]);
            default: return $urandom_range(0, 1) ? 32767 : -32768;
        endcase
    endfunction

    task automatic feed_point(input int style);
        int c;
        c = $urandom_range(0, use_nc - 1);
        for (int k = 0; k < use_dims; k++) begin
            push_req(KIND_POINT, $urandom, k, point_coord(style, c, k));
        end
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] act,
                              input logic [CFG_DATA_W-1:0] dims);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ACTIVE;
        cfg_data <= act;
        @(posedge i_clk);
        cfg_idx  <= CFG_DIMS;
        cfg_data <= dims;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        use_nc   = (act == 0) ? 1 : ((act > NCENT) ? NCENT : int'(act));
        use_dims = (dims[DIMS_W-1:0] == 0) ? 1 :
                   ((dims[DIMS_W-1:0] > NDIMS) ? NDIMS : int'(dims[DIMS_W-1:0]));
    endtask

    initial begin
        int                    roll;
        int                    c;
        int                    k;
        int                    v;
        int                    report_set [5] = '{0, 3, 7, 14, 15};
        logic [CFG_DATA_W-1:0] act_set;
        logic [CFG_DATA_W-1:0] dims_set;

        req_if.valid          = 1'b0;
        req_if.kind           = KIND_LOAD;
        req_if.centroid_index = '0;
        req_if.dim_index      = '0;
        req_if.coord_value    = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full centroid table: duplicates 3 and 5, near pair 7 and 8, corners 14 and 15
        for (c = 0; c < NCENT; c++) begin
            for (k = 0; k < NDIMS; k++) begin
                case (c)
                    3, 5:    v = (k % 2) ? -256 * (k + 1) : 256 * (k + 1);
                    7, 8:    v = ((k % 2) ? -1000 : 1000) * (k + 1) +
                                 ((c == 8 && k == 0) ? 2 : 0);
                    14:      v = 32767;
                    15:      v = -32768;
                    default: v = $urandom;
                endcase
                load_centroid(c, k, v);
            end
        end

        // first point under the reset configuration
        for (k = 0; k < 3; k++) push_req(KIND_POINT, $urandom, k, point_coord(1, 0, k));

        write_regs(16, 4);
        for (k = 0; k < NDIMS; k++) push_req(KIND_POINT, $urandom, k, 32767);
        for (k = 0; k < NDIMS; k++) push_req(KIND_POINT, $urandom, k, -32768);
        for (k = 0; k < NDIMS; k++) begin
            push_req(KIND_POINT, $urandom, k, int'(cen_shadow[5][k]));
        end
        for (k = 0; k < NDIMS; k++) begin
            push_req(KIND_POINT, $urandom, k, (k == 0) ? 1001 : int'(cen_shadow[8][k]));
        end
        foreach (report_set[i]) push_req(KIND_REPORT, report_set[i], $urandom, $urandom);
        push_req(KIND_CLEAR, $urandom, $urandom, $urandom);
        push_req(KIND_REPORT, 7, $urandom, $urandom);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: write_regs(16, 4);
                1: write_regs(1, 1);
                2: write_regs(0, 0);
                3: write_regs(31, 7);
                4: write_regs(5, 5'b11010);
                5: write_regs(16, 3);
                default: begin
                    act_set  = CFG_DATA_W'($urandom);
                    dims_set = CFG_DATA_W'($urandom);
                    write_regs(act_set, dims_set);
                end
            endcase
            gap_on     = (p % 3 != 0);
            stall_pct  = (p % 4 == 1) ? 0 : $urandom_range(10, 70);
            items_sent = 0;
            while (items_sent < 90) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    feed_point($urandom_range(0, 3));
                end else if (roll < 78) begin
                    push_req(KIND_REPORT, $urandom, $urandom, $urandom);
                end else if (roll < 80) begin
                    push_req(KIND_CLEAR, $urandom, $urandom, $urandom);
                end else if (roll < 90) begin
                    c = $urandom_range(0, NCENT - 1);
                    k = $urandom_range(0, NDIMS - 1);
                    load_centroid(c, k, (roll < 85) ?
                                  int'(cen_shadow[$urandom_range(0, NCENT - 1)][k]) :
                                  int'($urandom));
                end else begin
                    push_req(KIND_POINT, $urandom, $urandom, $urandom);
                end
            end
        end

        // pile points into bucket 0, then report offsets across the row
        write_regs(1, 1);
        gap_on     = 1'b0;
        stall_free = 1'b1;
        push_req(KIND_CLEAR, $urandom, $urandom, $urandom);
        repeat (40) push_req(KIND_POINT, $urandom, 0, $urandom);
        write_regs(16, 1);
        push_req(KIND_REPORT, 0, $urandom, $urandom);
        push_req(KIND_REPORT, 1, $urandom, $urandom);
        repeat (12) feed_point(1);
        push_req(KIND_REPORT, 15, $urandom, $urandom);
        push_req(KIND_REPORT, 3, $urandom, $urandom);
        push_req(KIND_CLEAR, $urandom, $urandom, $urandom);
        push_req(KIND_REPORT, 15, $urandom, $urandom);
        stall_free = 1'b0;

        settle();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[nearest_centroid_partition.f]
rtl/ncp_pkg.sv
rtl/ncp_req_if.sv
rtl/ncp_rsp_if.sv
rtl/ncp_cell.sv
rtl/nearest_centroid_partition.sv
rtl/ncp_checker.sv
dv/ncp_checker.sv
dv/tb.sv
